// ===== design/smm_pkg.sv =====
// Shared types and constants for the square matrix multiply unit.
`timescale 1ns / 1ps

package smm_pkg;

  localparam int SUM_W = 40;
  localparam int IDX_FIELD_W = 6;
  localparam int VALUE_W = 16;
  localparam int DIM_CFG_W = 7;
  localparam int DIM_RESET = 64;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_ROW    = 2'd2;

  typedef struct packed {
    logic [1:0]                    func;
    logic [IDX_FIELD_W-1:0]        row;
    logic [IDX_FIELD_W-1:0]        col;
    logic signed [VALUE_W-1:0]     value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0]        out_row;
    logic [IDX_FIELD_W-1:0]        out_col;
    logic signed [SUM_W-1:0]       sum;
    logic                          last;
  } out_item_t;

  // Tag that travels with each operand pair through the MAC pipeline.
  typedef struct packed {
    logic                          vld;
    logic                          first;
    logic                          last_k;
    logic                          last_col;
    logic [IDX_FIELD_W-1:0]        row;
    logic [IDX_FIELD_W-1:0]        col;
  } mac_tag_t;

endpackage

// ===== design/smm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/smm_mac.sv =====
// Shared multiply-accumulate pipeline and result register.
`timescale 1ns / 1ps

module smm_mac
  import smm_pkg::*;
#(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mac_tag_t              tag_in,
  input  logic [ELEM_WIDTH-1:0] a_data,
  input  logic [ELEM_WIDTH-1:0] b_data,
  input  logic                  out_stall,
  output logic                  adv,
  output logic                  busy,
  output logic                  out_valid,
  output out_item_t             out_data
);

  mac_tag_t                       s1_r, s2_r;
  logic signed [2*ELEM_WIDTH-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]        acc_r, acc_nxt;
  logic                           out_valid_r;
  out_item_t                      out_data_r;

  // Hold the whole pipeline while a finished result waits on the receiver.
  assign adv  = !out_valid_r || !out_stall;
  assign busy = s1_r.vld || s2_r.vld;

  assign prod_nxt = $signed(a_data) * $signed(b_data);
  assign acc_nxt  = (s2_r.first ? '0 : acc_r) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld    <= 1'b0;
      s2_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_r <= tag_in;
        s2_r <= s1_r;
        prod_r <= prod_nxt;
        if (s2_r.vld) begin
          acc_r <= acc_nxt;
        end
        if (s2_r.vld && s2_r.last_k) begin
          out_valid_r        <= 1'b1;
          out_data_r.out_row <= s2_r.row;
          out_data_r.out_col <= s2_r.col;
          out_data_r.sum     <= acc_nxt;
          out_data_r.last    <= s2_r.last_col;
        end else if (out_valid_r) begin
          // adv with a pending result means it was taken this cycle
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/square_matrix_multiply_unit.sv =====
// Top level of the square matrix multiply unit: sequencer, element stores and MAC.
// Usage:
//   Input channel (in_valid/in_stall/in_data): func 0 and 1 write one element of
//   A or B; func 2 computes one row of A*B for the side length in cfg register
//   dim_in_use; a row at or beyond that side, and func 3, are dropped.
//   Result channel (out_valid/out_stall/out_data): a compute request returns one
//   result per column, column order, last set on the final column.
//   Datapath: one shared multiplier reads A[row][k] and B[k][col] from the two
//   element RAMs each cycle while the result register is not stalled; a compute
//   request steps k within each column and the columns in order, and in_stall
//   stays high until the last column has left MAC stages s1 and s2.
//   A result sits in an output register; while the receiver stalls it, the MAC
//   pipeline and RAM reads hold. The next request is taken while the last result
//   of the previous row still waits.
//   Reset (rst_n low, synchronous) idles the sequencer, empties the pipeline and
//   sets dim_in_use to 64. Element stores are not cleared and must be written
//   before they are read. The user must write dim_in_use via cfg_we/cfg_wdata only
//   while idle (not enforced); 0 acts as 1 and values above MAX_DIM act as MAX_DIM.
`timescale 1ns / 1ps

module square_matrix_multiply_unit
  import smm_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [DIM_CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int DIM_RST = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       j_r, j_nxt, k_r, k_nxt;
  logic [IDX_FIELD_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0]       dim_r, dim_nxt;

  logic                   in_accept, load_ok, start;
  logic                   k_last, j_last;
  logic                   adv, busy;
  logic                   we_a, we_b;
  logic [ADDR_W-1:0]      waddr, a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0]  wdata, a_data, b_data;
  mac_tag_t               tag;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign load_ok = (32'(in_data.row) < 32'(MAX_DIM)) && (32'(in_data.col) < 32'(MAX_DIM));
  assign we_a    = in_accept && load_ok && (in_data.func == FUNC_LOAD_A);
  assign we_b    = in_accept && load_ok && (in_data.func == FUNC_LOAD_B);
  assign start   = in_accept && (in_data.func == FUNC_ROW)
                   && (32'(in_data.row) < 32'(dim_r));
  assign waddr   = {IDX_W'(in_data.row), IDX_W'(in_data.col)};
  assign wdata   = ELEM_WIDTH'(in_data.value);

  assign a_raddr = {IDX_W'(row_r), k_r};
  assign b_raddr = {k_r, j_r};

  assign k_last = (CNT_W'(k_r) == dim_r - CNT_W'(1));
  assign j_last = (CNT_W'(j_r) == dim_r - CNT_W'(1));

  always_comb begin
    tag.vld      = (state_r == ST_RUN);
    tag.first    = (k_r == '0);
    tag.last_k   = k_last;
    tag.last_col = j_last;
    tag.row      = row_r;
    tag.col      = IDX_FIELD_W'(j_r);
  end

  always_comb begin
    dim_nxt = dim_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        dim_nxt = CNT_W'(1);
      end else if (32'(cfg_wdata) > 32'(MAX_DIM)) begin
        dim_nxt = CNT_W'(MAX_DIM);
      end else begin
        dim_nxt = CNT_W'(cfg_wdata);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          j_nxt     = '0;
          k_nxt     = '0;
          row_nxt   = in_data.row;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (k_last) begin
            k_nxt = '0;
            if (j_last) begin
              state_nxt = ST_DRAIN;
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dim_r   <= CNT_W'(DIM_RST);
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
    end
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    row_r <= row_nxt;
  end

  smm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  smm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  smm_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (tag),
    .a_data    (a_data),
    .b_data    (b_data),
    .out_stall (out_stall),
    .adv       (adv),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== design/smm_checker.sv =====
// Port-level assertions for the square matrix multiply unit, bound to the top level.
`timescale 1ns / 1ps

module smm_checker
  import smm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Nothing pending and nothing in flight right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // A load is taken only with the pipeline empty and gives no result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid
    && (in_data.func == FUNC_LOAD_A || in_data.func == FUNC_LOAD_B)
    |=> !out_valid)
    else $error("load request produced a result");

  // Row zero is always inside the side in use, so the block must go busy.
  a_row0_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.func == FUNC_ROW && in_data.row == '0
    |=> in_stall)
    else $error("compute request on row zero not started");

endmodule

bind square_matrix_multiply_unit smm_checker u_smm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
